FILE: rtl/sgsd_pkg.sv
package sgsd_pkg;

  // Grid geometry and position width
  localparam int GRID_COLS     = 4;
  localparam int GRID_ROWS     = 8;
  localparam int POSITION_BITS = 16;

  localparam int MOTOR_COUNT = GRID_COLS * GRID_ROWS;
  localparam int BOARD_COLS  = (GRID_COLS + 1) / 2;
  localparam int BOARD_ROWS  = (GRID_ROWS + 1) / 2;
  localparam int BOARD_COUNT = BOARD_COLS * BOARD_ROWS;

  localparam int ADDR_W   = $clog2(MOTOR_COUNT);
  localparam int COL_W    = $clog2(GRID_COLS);
  localparam int ROW_W    = $clog2(GRID_ROWS);
  localparam int BOARD_IW = (BOARD_COUNT > 1) ? $clog2(BOARD_COUNT) : 1;

  // Request opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef logic signed [POSITION_BITS-1:0] pos_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    pos_t              data;
  } store_wr_t;

endpackage

FILE: rtl/sgsd_req_if.sv
interface sgsd_req_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [1:0]         motor_col;
  logic [2:0]         motor_row;
  logic signed [15:0] target_position;

  modport source (
    output valid, op, motor_col, motor_row, target_position,
    input  ready
  );
  modport sink (
    input  valid, op, motor_col, motor_row, target_position,
    output ready
  );
endinterface

FILE: rtl/sgsd_rsp_if.sv
interface sgsd_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] board_number;
  logic [7:0] drive_byte;
  logic       all_in_place;
  logic       last_byte;

  modport source (
    output valid, board_number, drive_byte, all_in_place, last_byte,
    input  ready
  );
  modport sink (
    input  valid, board_number, drive_byte, all_in_place, last_byte,
    output ready
  );
endinterface

FILE: rtl/sgsd_motor_store.sv
module sgsd_motor_store import sgsd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  store_wr_t         tgt_wr,
  input  store_wr_t         pos_wr,
  input  logic [ADDR_W-1:0] rd_addr,
  output pos_t              rd_pos,
  output pos_t              rd_tgt
);

  pos_t pos_mem [MOTOR_COUNT];
  pos_t tgt_mem [MOTOR_COUNT];

  logic [MOTOR_COUNT-1:0] pos_vld;
  logic [MOTOR_COUNT-1:0] tgt_vld;

  pos_t pos_q;
  pos_t tgt_q;
  logic pos_v_q;
  logic tgt_v_q;

  // data arrays, registered read
  always_ff @(posedge clk) begin
    if (tgt_wr.we) begin
      tgt_mem[tgt_wr.addr] <= tgt_wr.data;
    end
    if (pos_wr.we) begin
      pos_mem[pos_wr.addr] <= pos_wr.data;
    end
    pos_q <= pos_mem[rd_addr];
    tgt_q <= tgt_mem[rd_addr];
  end

  // per-entry valid: unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_vld <= '0;
      tgt_vld <= '0;
      pos_v_q <= 1'b0;
      tgt_v_q <= 1'b0;
    end else begin
      if (tgt_wr.we) begin
        tgt_vld[tgt_wr.addr] <= 1'b1;
      end
      if (pos_wr.we) begin
        pos_vld[pos_wr.addr] <= 1'b1;
      end
      pos_v_q <= pos_vld[rd_addr];
      tgt_v_q <= tgt_vld[rd_addr];
    end
  end

  assign rd_pos = pos_v_q ? pos_q : '0;
  assign rd_tgt = tgt_v_q ? tgt_q : '0;

endmodule

FILE: rtl/stepper_grid_step_direction_packer.sv
// Load request: accepted while idle, no response beats.
// Step request: reads all 32 motors, one motor per cycle through the store's single read port,
//   then, after the store's registered read, one response beat per board (8), back to back
//   while rsp is ready.
// Reset (rst, synchronous): all positions and targets read as zero, control returns to idle.
module stepper_grid_step_direction_packer import sgsd_pkg::*; (
  input logic         clk,
  input logic         rst,
  sgsd_req_if.sink    req,
  sgsd_rsp_if.source  rsp
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state;

  // scan walk: column outer, row inner, same order as the store address
  logic [COL_W-1:0] scan_col;
  logic [ROW_W-1:0] scan_row;
  logic             scan_busy;
  logic             scan_last;
  logic [ADDR_W-1:0] scan_addr;
  logic [BOARD_IW-1:0] scan_board;

  // stage 1: store data returns, compare and write back
  logic                s1_vld;
  logic [ADDR_W-1:0]   s1_addr;
  logic [BOARD_IW-1:0] s1_board;
  logic [1:0]          s1_slot;
  logic                s1_last;

  pos_t rd_pos;
  pos_t rd_tgt;
  logic s1_diff;
  logic s1_down;
  logic [7:0] s1_mask;

  // per-board drive bytes collected during the scan
  logic [7:0]          drive [BOARD_COUNT];
  logic                moved;
  logic [BOARD_IW-1:0] emit_idx;
  logic                emit_last;

  store_wr_t tgt_wr;
  store_wr_t pos_wr;

  logic req_fire;
  logic rsp_fire;
  logic in_grid;

  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign rsp_fire  = rsp.valid && rsp.ready;

  assign in_grid = (32'(req.motor_col) < GRID_COLS) && (32'(req.motor_row) < GRID_ROWS);

  // target writes happen only from an idle load inside the grid; out-of-grid loads are dropped
  always_comb begin
    tgt_wr.we   = req_fire && (req.op == OP_LOAD) && in_grid;
    tgt_wr.addr = ADDR_W'(32'(req.motor_col) * GRID_ROWS + 32'(req.motor_row));
    tgt_wr.data = POSITION_BITS'(req.target_position);
  end

  assign scan_addr  = ADDR_W'(32'(scan_col) * GRID_ROWS + 32'(scan_row));
  assign scan_last  = (32'(scan_col) == GRID_COLS - 1) && (32'(scan_row) == GRID_ROWS - 1);
  assign scan_board = BOARD_IW'(32'(scan_col >> 1) + 32'(scan_row >> 1) * BOARD_COLS);

  sgsd_motor_store u_store (
    .clk     (clk),
    .rst     (rst),
    .tgt_wr  (tgt_wr),
    .pos_wr  (pos_wr),
    .rd_addr (scan_addr),
    .rd_pos  (rd_pos),
    .rd_tgt  (rd_tgt)
  );

  // compare; direction bit set when heading toward smaller positions
  assign s1_diff = (rd_tgt != rd_pos);
  assign s1_down = (rd_tgt < rd_pos);
  assign s1_mask = (8'(s1_diff) << {s1_slot, 1'b1}) | (8'(s1_down) << {s1_slot, 1'b0});

  // read-modify-write of the position; a pass touches each entry once, so no overlap
  always_comb begin
    pos_wr.we   = s1_vld && s1_diff;
    pos_wr.addr = s1_addr;
    pos_wr.data = s1_down ? (rd_pos - pos_t'(1)) : (rd_pos + pos_t'(1));
  end

  assign emit_last = (emit_idx == BOARD_IW'(BOARD_COUNT - 1));

  assign rsp.valid        = (state == ST_EMIT);
  assign rsp.board_number = 3'(emit_idx);
  assign rsp.drive_byte   = drive[emit_idx];
  assign rsp.all_in_place = !moved;
  assign rsp.last_byte    = emit_last;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_col  <= '0;
      scan_row  <= '0;
      scan_busy <= 1'b0;
      s1_vld    <= 1'b0;
      emit_idx  <= '0;
    end else begin
      s1_vld <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (req_fire && (req.op == OP_STEP)) begin
            state     <= ST_SCAN;
            scan_col  <= '0;
            scan_row  <= '0;
            scan_busy <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (scan_busy) begin
            s1_vld <= 1'b1;
            if (scan_last) begin
              scan_busy <= 1'b0;
            end else if (32'(scan_row) == GRID_ROWS - 1) begin
              scan_row <= '0;
              scan_col <= scan_col + COL_W'(1);
            end else begin
              scan_row <= scan_row + ROW_W'(1);
            end
          end
          if (s1_vld && s1_last) begin
            state    <= ST_EMIT;
            emit_idx <= '0;
          end
        end
        ST_EMIT: begin
          if (rsp_fire) begin
            if (emit_last) begin
              state <= ST_IDLE;
            end else begin
              emit_idx <= emit_idx + BOARD_IW'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    s1_addr  <= scan_addr;
    s1_board <= scan_board;
    s1_slot  <= {scan_col[0], scan_row[0]};
    s1_last  <= scan_last;
  end

  // drive bytes and moved flag: cleared at the start of each pass
  always_ff @(posedge clk) begin
    if (req_fire && (req.op == OP_STEP)) begin
      for (int b = 0; b < BOARD_COUNT; b++) begin
        drive[b] <= '0;
      end
      moved <= 1'b0;
    end else if (s1_vld) begin
      drive[s1_board] <= drive[s1_board] | s1_mask;
      if (s1_diff) begin
        moved <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // positions change only during a scan
  a_pos_wr_in_scan: assert property (@(posedge clk) disable iff (rst)
    pos_wr.we |-> (state == ST_SCAN))
    else $error("position write outside scan");

  // last beat of a pass carries the highest board index
  a_last_board: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.last_byte) |-> (32'(rsp.board_number) == BOARD_COUNT - 1))
    else $error("last beat on wrong board");

  // the in-place flag is the same on every beat of a pass
  a_flag_stable: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && $past(rsp.valid)) |-> $stable(rsp.all_in_place))
    else $error("all_in_place changed within a pass");

  // no new request while beats are pending
  a_no_req_in_emit: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready)
    else $error("request taken during emit");

endmodule
